@@ sv/gradient_noise_2d_top_defines.svh @@
// ----------------------------------------------------------------------------
// gradient noise assertion macros
// shared assertion wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_TOP_DEFINES_SVH
`define GRADIENT_NOISE_2D_TOP_DEFINES_SVH

// clocked check, masked while reset is high
`define GN_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gradient noise check failed");

// clocked check that also holds through reset
`define GN_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("gradient noise reset check failed");

`endif

@@ sv/gn2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d package
// shared types, constants and arithmetic helpers for gradient noise
// ----------------------------------------------------------------------------
package gn2d_pkg;

   localparam int GN_TABLE_DEPTH   = 1024;
   localparam int GN_GRID_HALF_MAX = 15;
   localparam int REQ_DATA_W       = 80;
   localparam int RSP_DATA_W       = 16;
   localparam int CSR_DATA_W       = 10;

   localparam logic CSR_CELL_SIZE = 1'b0;
   localparam logic CSR_GRID_HALF = 1'b1;

   typedef enum logic [16:0] {
      S_IDLE   = 17'd1,
      S_WRITE  = 17'd2,
      S_PDIV   = 17'd4,
      S_PWAIT  = 17'd8,
      S_FDIV   = 17'd16,
      S_FWAIT  = 17'd32,
      S_CSET   = 17'd64,
      S_CREAD  = 17'd128,
      S_SQSUM  = 17'd256,
      S_SQWAIT = 17'd512,
      S_MUL    = 17'd1024,
      S_DDIV   = 17'd2048,
      S_DWAIT  = 17'd4096,
      S_LERPA  = 17'd8192,
      S_LERPB  = 17'd16384,
      S_LERPC  = 17'd32768,
      S_FINISH = 17'd65536
   } state_type;

   typedef enum logic [1:0] {
      SRC_POS,
      SRC_FRAC,
      SRC_DOT
   } src_type;

   typedef struct packed {
      logic       capture;
      logic       tab_write;
      logic       div_start;
      logic       div_take;
      src_type    div_src;
      logic       axis;
      logic [1:0] corner;
      logic       corner_set;
      logic       corner_read;
      logic       sqrt_start;
      logic       mul;
      logic       lerp_a;
      logic       lerp_b;
      logic       lerp_c;
      logic       finish;
   } ctl_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
   } sts_type;

   // clamp to [-1, 1] in q1.14
   function automatic logic signed [15:0] clamp_q14(input logic signed [15:0] v);
      logic signed [15:0] r;
      r = v;
      if (v > 16'sd16384) r = 16'sd16384;
      if (v < -16'sd16384) r = -16'sd16384;
      return r;
   endfunction

   // p / 2^14 rounded to nearest, ties away from zero
   function automatic logic signed [19:0] rnd_q14(input logic signed [33:0] p);
      logic [33:0] mag;
      logic [33:0] q;
      mag = p[33] ? 34'(-p) : p;
      q   = (mag + 34'd8192) >> 14;
      return p[33] ? 20'(-q) : 20'(q);
   endfunction

endpackage

@@ sv/gradient_noise_2d_top.sv @@
`timescale 1ns / 1ps
// a load word is captured on accept and written to the table in the next cycle, req_tready low meanwhile
// a sample is accepted only while idle, so no new word is taken until the sample's result is registered
// each sample uses the shared divider (16 + 24 bits per axis, 30 bits per corner)
// and the 15-step square root, which runs once for each of the four corners
// reset: synchronous, active high; clears control, sets cell_size to 1 and grid_half to 0
// the gradient table is not cleared and holds garbage until written
// ----------------------------------------------------------------------------
// gradient noise 2d top
// perlin style gradient noise sampler with a loadable gradient table
// ----------------------------------------------------------------------------
module gradient_noise_2d_top #(
   parameter int TABLE_DEPTH   = gn2d_pkg::GN_TABLE_DEPTH,
   parameter int GRID_HALF_MAX = gn2d_pkg::GN_GRID_HALF_MAX
) (
   input  logic                            clock,
   input  logic                            reset,
   // input words
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index[9:0] grad_x[25:10] grad_y[41:26] pos_x[57:42] pos_y[73:58], zero pad
   input  logic [gn2d_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type: 0 load a table entry, 1 sample
   input  logic                            req_tuser,
   // result words
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // noise_value[15:0]
   output logic [gn2d_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register writes: 0 cell_size, 1 grid_half
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [gn2d_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gn2d_pkg::*;

   // command and status between sequencer and arithmetic
   ctl_type ctl;
   sts_type sts;

   // sequencer: owns the handshakes, the axis and corner counters
   gn2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl),
      .sts        (sts)
   );

   // arithmetic, table memory and the result register
   gn2d_dpath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .GRID_HALF_MAX (GRID_HALF_MAX)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_value (rsp_tdata),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule

@@ sv/gn2d_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d controller
// sequences table loads and the split, corner dot and blend steps of one item at a time
// ----------------------------------------------------------------------------
module gn2d_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output gn2d_pkg::ctl_type ctl,
   input  gn2d_pkg::sts_type sts
);
   import gn2d_pkg::*;

   state_type  state_ff, state_in;
   logic       axis_ff, axis_in;
   logic [1:0] corner_ff, corner_in;
   logic       valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         axis_ff   <= 1'b0;
         corner_ff <= 2'd0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         axis_ff   <= axis_in;
         corner_ff <= corner_in;
         valid_ff  <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      corner_in  = corner_ff;
      valid_in   = valid_ff && !rsp_tready;
      ctl        = '0;
      ctl.axis   = axis_ff;
      ctl.corner = corner_ff;
      ctl.div_src = SRC_POS;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               axis_in     = 1'b0;
               state_in    = req_tuser ? S_PDIV : S_WRITE;
            end
         end
         S_WRITE: begin
            ctl.tab_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_PDIV: begin
            ctl.div_start = 1'b1;
            state_in      = S_PWAIT;
         end
         S_PWAIT: begin
            if (!sts.div_busy) begin
               ctl.div_take = 1'b1;
               state_in     = S_FDIV;
            end
         end
         S_FDIV: begin
            ctl.div_src   = SRC_FRAC;
            ctl.div_start = 1'b1;
            state_in      = S_FWAIT;
         end
         S_FWAIT: begin
            ctl.div_src = SRC_FRAC;
            if (!sts.div_busy) begin
               ctl.div_take = 1'b1;
               if (axis_ff) begin
                  corner_in = 2'd0;
                  state_in  = S_CSET;
               end else begin
                  axis_in  = 1'b1;
                  state_in = S_PDIV;
               end
            end
         end
         S_CSET: begin
            ctl.corner_set = 1'b1;
            state_in       = S_CREAD;
         end
         S_CREAD: begin
            ctl.corner_read = 1'b1;
            state_in        = S_SQSUM;
         end
         S_SQSUM: begin
            ctl.sqrt_start = 1'b1;
            state_in       = S_SQWAIT;
         end
         S_SQWAIT: begin
            if (!sts.sqrt_busy) state_in = S_MUL;
         end
         S_MUL: begin
            ctl.mul  = 1'b1;
            state_in = S_DDIV;
         end
         S_DDIV: begin
            ctl.div_src   = SRC_DOT;
            ctl.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            ctl.div_src = SRC_DOT;
            if (!sts.div_busy) begin
               ctl.div_take = 1'b1;
               if (corner_ff == 2'd3) begin
                  state_in = S_LERPA;
               end else begin
                  corner_in = corner_ff + 2'd1;
                  state_in  = S_CSET;
               end
            end
         end
         S_LERPA: begin
            ctl.lerp_a = 1'b1;
            state_in   = S_LERPB;
         end
         S_LERPB: begin
            ctl.lerp_b = 1'b1;
            state_in   = S_LERPC;
         end
         S_LERPC: begin
            ctl.lerp_c = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               ctl.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ sv/gn2d_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d datapath
// gradient table, shared divider, square root unit, dot and blend arithmetic
// ----------------------------------------------------------------------------
module gn2d_dpath #(
   parameter int TABLE_DEPTH   = gn2d_pkg::GN_TABLE_DEPTH,
   parameter int GRID_HALF_MAX = gn2d_pkg::GN_GRID_HALF_MAX
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_addr,
   input  logic [gn2d_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [gn2d_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic [gn2d_pkg::RSP_DATA_W-1:0]   rsp_value,
   input  gn2d_pkg::ctl_type                 ctl,
   output gn2d_pkg::sts_type                 sts
);
   import gn2d_pkg::*;

   localparam int          AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [12:0] DEPTH13 = 13'(TABLE_DEPTH);
   localparam logic [4:0]  GMAX    = 5'(GRID_HALF_MAX);

   // configuration
   logic [9:0] cell_size_ff;
   logic [3:0] grid_half_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= 10'd1;
         grid_half_ff <= 4'd0;
      end else if (csr_we) begin
         if (csr_addr == CSR_CELL_SIZE) cell_size_ff <= csr_wdata;
         if (csr_addr == CSR_GRID_HALF) grid_half_ff <= csr_wdata[3:0];
      end
   end

   logic [9:0] csz;
   logic [4:0] geff;
   assign csz  = (cell_size_ff == 10'd0) ? 10'd1 : cell_size_ff;
   assign geff = ({1'b0, grid_half_ff} > GMAX) ? GMAX : {1'b0, grid_half_ff};

   // captured item
   logic [9:0]         entry_ff;
   logic signed [15:0] gxi_ff, gyi_ff, posx_ff, posy_ff;
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         entry_ff <= req_tdata[9:0];
         gxi_ff   <= req_tdata[25:10];
         gyi_ff   <= req_tdata[41:26];
         posx_ff  <= req_tdata[57:42];
         posy_ff  <= req_tdata[73:58];
      end
   end

   // gradient table, gy in the upper half
   logic [31:0] mem [TABLE_DEPTH];
   logic [12:0] widx;
   logic [AW-1:0] addr_ff;
   logic [31:0] rd_ff;
   assign widx = {3'b0, entry_ff};
   always_ff @(posedge clock) begin
      if (ctl.tab_write && widx < DEPTH13)
         mem[widx[AW-1:0]] <= {clamp_q14(gyi_ff), clamp_q14(gxi_ff)};
      if (ctl.corner_read) rd_ff <= mem[addr_ff];
   end

   // shared restoring divider, one quotient bit per cycle
   logic [29:0] dsh_ff, quo_ff;
   logic [15:0] rem_ff;
   logic [14:0] dvs_ff;
   logic [4:0]  dcnt_ff;
   logic        dbusy_ff, dneg_ff;
   logic [15:0] dtry;
   logic        dge;
   assign dtry = {rem_ff[14:0], dsh_ff[29]};
   assign dge  = dtry >= {1'b0, dvs_ff};

   logic signed [15:0] pos_sel;
   logic [15:0]        pos_mag;
   assign pos_sel = ctl.axis ? posy_ff : posx_ff;
   assign pos_mag = pos_sel[15] ? 16'(-pos_sel) : pos_sel;

   logic [9:0]         rr_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [14:0]        root_ff;
   logic signed [32:0] dot_n;
   logic [32:0]        dot_mag;
   logic [14:0]        dlen;
   assign dot_n   = 33'(px_ff) + 33'(py_ff);
   assign dot_mag = dot_n[32] ? 33'(-dot_n) : dot_n;
   assign dlen    = (root_ff == 15'd0) ? 15'd1 : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (ctl.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && dcnt_ff == 5'd1) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_start) begin
         rem_ff <= 16'd0;
         quo_ff <= 30'd0;
         case (ctl.div_src)
            SRC_POS: begin
               dsh_ff  <= {pos_mag, 14'd0};
               dvs_ff  <= {5'd0, csz};
               dcnt_ff <= 5'd16;
            end
            SRC_FRAC: begin
               dsh_ff  <= {rr_ff, 20'd0};
               dvs_ff  <= {5'd0, csz};
               dcnt_ff <= 5'd24;
            end
            default: begin
               dsh_ff  <= 30'(dot_mag) + 30'(dlen >> 1);
               dvs_ff  <= dlen;
               dcnt_ff <= 5'd30;
               dneg_ff <= dot_n[32];
            end
         endcase
      end else if (dbusy_ff) begin
         rem_ff  <= dge ? dtry - {1'b0, dvs_ff} : dtry;
         quo_ff  <= {quo_ff[28:0], dge};
         dsh_ff  <= {dsh_ff[28:0], 1'b0};
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   // floor split results
   logic signed [17:0] cx_ff, cy_ff;
   logic [13:0]        fx_ff, fy_ff;
   logic signed [17:0] dot_ff [4];
   logic signed [17:0] qs, corner_v;
   logic               rnz;
   assign qs  = {2'b0, quo_ff[15:0]};
   assign rnz = rem_ff[9:0] != 10'd0;
   always_comb begin
      if (pos_sel[15] && rnz) corner_v = -qs - 18'sd1;
      else if (pos_sel[15])   corner_v = -qs;
      else                    corner_v = qs;
   end

   always_ff @(posedge clock) begin
      if (ctl.div_take) begin
         case (ctl.div_src)
            SRC_POS: begin
               if (ctl.axis) cy_ff <= corner_v;
               else          cx_ff <= corner_v;
               rr_ff <= (pos_sel[15] && rnz) ? csz - rem_ff[9:0] : rem_ff[9:0];
            end
            SRC_FRAC: begin
               if (ctl.axis) fy_ff <= quo_ff[13:0];
               else          fx_ff <= quo_ff[13:0];
            end
            default: begin
               dot_ff[ctl.corner] <= dneg_ff ? 18'(-quo_ff[17:0]) : quo_ff[17:0];
            end
         endcase
      end
   end

   // corner address and offsets
   logic signed [17:0] gs, cxk, cyk;
   logic [5:0]         ux, uy, stride;
   logic [12:0]        cidx;
   logic               in_grid;
   logic signed [15:0] dx_ff, dy_ff;
   logic               gsel_ff;
   assign gs      = {13'd0, geff};
   assign cxk     = cx_ff + {17'd0, ctl.corner[1]};
   assign cyk     = cy_ff + {17'd0, ctl.corner[0]};
   assign ux      = 6'(cxk + gs);
   assign uy      = 6'(cyk + gs);
   assign stride  = {geff, 1'b1};
   assign cidx    = 13'({7'd0, ux} * {7'd0, stride}) + {7'd0, uy};
   assign in_grid = (cxk >= -gs) && (cxk <= gs) && (cyk >= -gs) && (cyk <= gs);

   always_ff @(posedge clock) begin
      if (ctl.corner_set) begin
         gsel_ff <= in_grid && (cidx < DEPTH13);
         addr_ff <= cidx[AW-1:0];
         dx_ff   <= ctl.corner[1] ? 16'({2'b0, fx_ff}) - 16'sd16384 : {2'b0, fx_ff};
         dy_ff   <= ctl.corner[0] ? 16'({2'b0, fy_ff}) - 16'sd16384 : {2'b0, fy_ff};
      end
   end

   // squared length, then bit-pair square root
   logic [29:0] sqx_ff, sqy_ff, ssh_ff;
   logic [15:0] srem_ff;
   logic [3:0]  scnt_ff;
   logic        sbusy_ff;
   logic [17:0] srem2, strial;
   logic        sge;
   assign srem2  = {srem_ff, ssh_ff[29:28]};
   assign strial = {1'b0, root_ff, 2'b01};
   assign sge    = srem2 >= strial;

   always_ff @(posedge clock) begin
      if (ctl.corner_read) begin
         sqx_ff <= 30'(32'(dx_ff) * 32'(dx_ff));
         sqy_ff <= 30'(32'(dy_ff) * 32'(dy_ff));
      end
      if (ctl.sqrt_start) begin
         ssh_ff  <= sqx_ff + sqy_ff;
         srem_ff <= 16'd0;
         root_ff <= 15'd0;
         scnt_ff <= 4'd15;
      end else if (sbusy_ff) begin
         srem_ff <= sge ? 16'(srem2 - strial) : 16'(srem2);
         root_ff <= {root_ff[13:0], sge};
         ssh_ff  <= {ssh_ff[27:0], 2'b00};
         scnt_ff <= scnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (ctl.sqrt_start) begin
         sbusy_ff <= 1'b1;
      end else if (sbusy_ff && scnt_ff == 4'd1) begin
         sbusy_ff <= 1'b0;
      end
   end

   // gradient dot offset
   logic signed [15:0] gx, gy;
   assign gx = gsel_ff ? rd_ff[15:0]  : 16'sd16384;
   assign gy = gsel_ff ? rd_ff[31:16] : 16'sd0;
   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         px_ff <= gx * dx_ff;
         py_ff <= gy * dy_ff;
      end
   end

   // blend along y, then along x
   logic signed [33:0] p1_ff, p2_ff;
   logic signed [19:0] l1_ff, l2_ff;
   logic signed [18:0] dya, dyb;
   logic signed [20:0] dxl, vfull;
   logic signed [14:0] ty, tx;
   logic [15:0]        out_ff;
   assign ty    = {1'b0, fy_ff};
   assign tx    = {1'b0, fx_ff};
   assign dya   = 19'(dot_ff[1]) - 19'(dot_ff[0]);
   assign dyb   = 19'(dot_ff[3]) - 19'(dot_ff[2]);
   assign dxl   = 21'(l2_ff) - 21'(l1_ff);
   assign vfull = 21'(l1_ff) + 21'(rnd_q14(p1_ff));

   always_ff @(posedge clock) begin
      if (ctl.lerp_a) begin
         p1_ff <= 34'(dya) * 34'(ty);
         p2_ff <= 34'(dyb) * 34'(ty);
      end
      if (ctl.lerp_b) begin
         l1_ff <= 20'(dot_ff[0]) + rnd_q14(p1_ff);
         l2_ff <= 20'(dot_ff[2]) + rnd_q14(p2_ff);
      end
      if (ctl.lerp_c) p1_ff <= 34'(dxl) * 34'(tx);
      if (ctl.finish) begin
         if (vfull > 21'sd16384)       out_ff <= 16'h4000;
         else if (vfull < -21'sd16384) out_ff <= 16'hC000;
         else                          out_ff <= vfull[15:0];
      end
   end

   assign rsp_value     = out_ff;
   assign sts.div_busy  = dbusy_ff;
   assign sts.sqrt_busy = sbusy_ff;

endmodule

@@ sv/gn2d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d checker
// port level checks on the result and request channels of the noise block
// ----------------------------------------------------------------------------
`include "gradient_noise_2d_top_defines.svh"

module gn2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   `GN_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `GN_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `GN_ASSERT(a_range, rsp_tvalid |-> ($signed(rsp_tdata) <= 16'sd16384 && $signed(rsp_tdata) >= -16'sd16384))
   `GN_ASSERT(a_load_silent, req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
   `GN_ASSERT_RST(a_reset_idle, reset |=> !rsp_tvalid)

endmodule

bind gradient_noise_2d_top gn2d_checker u_gn2d_checker (.*);

@@ tb/gradient_noise_2d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient noise 2d checker
// watches the word channels and register writes, predicts each noise sample
// from a private copy of the gradient table and compares it with the result
// ----------------------------------------------------------------------------
module gradient_noise_2d_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [gn2d_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [gn2d_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [gn2d_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              errors,
   output int                              pending
);
   import gn2d_pkg::*;

   localparam longint Q14_ONE = 16384;

   longint           grad_tab_x [GN_TABLE_DEPTH];
   longint           grad_tab_y [GN_TABLE_DEPTH];
   logic [9:0]       cell_reg;
   logic [3:0]       grid_reg;
   logic signed [15:0] noise_q [$];

   function automatic longint clamp_one(input longint v);
      if (v > Q14_ONE) return Q14_ONE;
      if (v < -Q14_ONE) return -Q14_ONE;
      return v;
   endfunction

   // rounded to nearest, ties away from zero
   function automatic longint round_div(input longint n, input longint d);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q   = (mag + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint int_sqrt(input longint s_in);
      longint s;
      longint r;
      longint b;
      s = s_in;
      r = 0;
      b = 64'sd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint corner_dot(input longint cx, input longint cy,
                                         input longint dx, input longint dy);
      longint g;
      longint gx;
      longint gy;
      longint idx;
      longint s;
      g  = (grid_reg > GN_GRID_HALF_MAX) ? GN_GRID_HALF_MAX : grid_reg;
      gx = Q14_ONE;
      gy = 0;
      // corners outside the grid point along +x
      if (cx >= -g && cx <= g && cy >= -g && cy <= g) begin
         idx = (cx + g) * (2 * g + 1) + (cy + g);
         if (idx >= 0 && idx < GN_TABLE_DEPTH) begin
            gx = grad_tab_x[idx];
            gy = grad_tab_y[idx];
         end
      end
      s = dx * dx + dy * dy;
      if (s == 0) return 0;
      return round_div(gx * dx + gy * dy, int_sqrt(s));
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint t);
      return a + round_div((b - a) * t, Q14_ONE);
   endfunction

   // floor division, fraction in q14
   function automatic void cell_of(input longint p, input longint c,
                                   output longint corner, output longint frac);
      longint q;
      longint r;
      q = p / c;
      r = p % c;
      if (r < 0) begin
         r = r + c;
         q = q - 1;
      end
      corner = q;
      frac   = (r * Q14_ONE) / c;
   endfunction

   function automatic logic signed [15:0] noise_at(input longint px, input longint py);
      longint c;
      longint cx;
      longint cy;
      longint fx;
      longint fy;
      longint d11;
      longint d12;
      longint d21;
      longint d22;
      c = (cell_reg == 0) ? 1 : cell_reg;
      cell_of(px, c, cx, fx);
      cell_of(py, c, cy, fy);
      d11 = corner_dot(cx, cy, fx, fy);
      d12 = corner_dot(cx, cy + 1, fx, fy - Q14_ONE);
      d21 = corner_dot(cx + 1, cy, fx - Q14_ONE, fy);
      d22 = corner_dot(cx + 1, cy + 1, fx - Q14_ONE, fy - Q14_ONE);
      return 16'(clamp_one(blend(blend(d11, d12, fy), blend(d21, d22, fy), fx)));
   endfunction

   assign pending = noise_q.size();

   initial errors = 0;

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         cell_reg <= 10'd1;
         grid_reg <= 4'd0;
         noise_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_CELL_SIZE) cell_reg <= csr_wdata;
            else if (csr_addr == CSR_GRID_HALF) grid_reg <= csr_wdata[3:0];
         end
         if (req_tvalid && req_tready) begin
            if (!req_tuser) begin
               grad_tab_x[req_tdata[9:0]] = clamp_one($signed(req_tdata[25:10]));
               grad_tab_y[req_tdata[9:0]] = clamp_one($signed(req_tdata[41:26]));
            end else begin
               noise_q.push_back(noise_at($signed(req_tdata[57:42]),
                                          $signed(req_tdata[73:58])));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (noise_q.size() == 0) begin
               errors <= errors + 1;
               $display("%0t: unexpected noise word, got %0d", $time,
                        $signed(rsp_tdata));
            end else begin
               want = noise_q.pop_front();
               if (rsp_tdata !== want) begin
                  errors <= errors + 1;
                  $display("%0t: noise_value mismatch, expected %0d, got %0d",
                           $time, want, $signed(rsp_tdata));
               end
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient noise 2d testbench
// fills the gradient table, then runs directed and random load and sample
// words under a series of cell size and grid settings, with random stalls
// ----------------------------------------------------------------------------
module tb;
   import gn2d_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int LONG_HOLD      = 3000;
   localparam int FILL_GRID      = 10;   // largest grid half used by the run

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int  errors;
   int  pending;
   int  quiet_cycles;
   bit  no_gaps;          // stretches without idling on either side
   bit  long_hold_req;    // asks the receiver for one long stall
   int  cur_cell;
   int  cur_grid;

   gradient_noise_2d_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   gradient_noise_2d_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: ends the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random stall before each word, one long stall on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            n = LONG_HOLD;
            long_hold_req = 1'b0;
         end else begin
            n = no_gaps ? 0 : $urandom_range(0, 9);
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // one input word, starting and ending at a falling edge
   task automatic send_word(input logic kind, input logic [9:0] idx,
                            input logic [15:0] gx, input logic [15:0] gy,
                            input logic [15:0] px, input logic [15:0] py);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, py, px, gy, gx, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic load_entry(input int idx, input int gx, input int gy);
      send_word(1'b0, idx[9:0], gx[15:0], gy[15:0], 16'($urandom), 16'($urandom));
   endtask

   task automatic sample(input int px, input int py);
      send_word(1'b1, 10'($urandom), 16'($urandom), 16'($urandom), px[15:0], py[15:0]);
   endtask

   // block idle: sender quiet, every result back, a load finished
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(input logic addr, input int value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input int cell_sz, input int grid);
      drain();
      write_reg(CSR_CELL_SIZE, cell_sz);
      write_reg(CSR_GRID_HALF, grid);
      cur_cell = cell_sz;
      cur_grid = grid[3:0];
   endtask

   function automatic int rand_grad();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 65535) - 32768;  // clamped on load
         1:       return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
         default: return $urandom_range(0, 32768) - 16384;
      endcase
   endfunction

   // position mostly inside the grid, now and then anywhere
   function automatic int rand_pos();
      int c;
      int span;
      c = (cur_cell == 0) ? 1 : cur_cell;
      span = (cur_grid + 2) * c;
      if (span > 32767 || $urandom_range(0, 9) == 0)
         return $urandom_range(0, 65535) - 32768;
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0)
            load_entry($urandom_range(0, 1023), rand_grad(), rand_grad());
         else
            sample(rand_pos(), rand_pos());
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      int cells [8];
      int grids [8];
      cells = '{16, 1023, 0, 7, 64, 3, 1, 200};
      grids = '{10, 10, 3, 10, 8, 1, 10, 9};
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_we        = 1'b0;
      csr_addr      = CSR_CELL_SIZE;
      csr_wdata     = '0;
      no_gaps       = 1'b0;
      long_hold_req = 1'b0;
      cur_cell      = 1;
      cur_grid      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every entry that a grid of up to FILL_GRID can reach, written first
      for (int i = 0; i < (2 * FILL_GRID + 1) * (2 * FILL_GRID + 1); i++)
         load_entry(i, rand_grad(), rand_grad());

      // directed words under reset settings: one cell, grid of one entry
      load_entry(0, 32767, -32768);
      load_entry(1023, -16384, 16384);
      sample(0, 0);
      sample(32767, 32767);
      sample(-32768, -32768);
      sample(-1, 1);
      sample(1, -1);
      load_entry(0, 0, 0);
      sample(0, 0);
      load_entry(0, 16384, -16384);
      sample(-1, -1);

      // cell size zero acts as one, largest cell with the widest grid used
      set_config(0, FILL_GRID);
      sample(0, 0);
      sample(15, -15);
      sample(-32768, 32767);
      set_config(1023, FILL_GRID);
      sample(512, -512);
      sample(16368, -16368);
      sample(32767, -32768);
      sample(1023, 1023);
      sample(-1, -1);

      // long receiver stall while samples keep coming
      no_gaps       = 1'b1;
      long_hold_req = 1'b1;
      for (int i = 0; i < 6; i++) sample(rand_pos(), rand_pos());
      no_gaps = 1'b0;

      for (int p = 0; p < 8; p++) begin
         set_config(cells[p], grids[p]);
         random_items(45);
      end
      // upper bits of the grid write are dropped by the block
      set_config($urandom_range(0, 1023),
                 16 * $urandom_range(0, 63) + $urandom_range(0, FILL_GRID));
      random_items(30);

      drain();
      repeat (50) @(negedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ gradient_noise_2d_top.f @@
+incdir+sv
sv/gn2d_pkg.sv
sv/gn2d_ctrl.sv
sv/gn2d_dpath.sv
sv/gradient_noise_2d_top.sv
sv/gn2d_checker.sv
tb/gradient_noise_2d_checker.sv
tb/tb.sv
